// File: rtl/serial_command_display_watchdog_assert.svh
// Assertion macros for the serial command, display and watchdog block.
// Included by the RTL files that check their own logic; needs nothing else.
`ifndef SERIAL_COMMAND_DISPLAY_WATCHDOG_ASSERT_SVH
`define SERIAL_COMMAND_DISPLAY_WATCHDOG_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCDW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scdw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCDW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scdw assertion failed");

`endif

// File: rtl/scdw_pkg.sv
// Types, constants and tables of the serial command, display and watchdog block.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none
package scdw_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    localparam logic [3:0]  BLANK_CODE     = 4'd10;
    localparam logic [15:0] WDOG_LIMIT_RST = 16'd32768;

    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_T  = 8'h54;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_C  = 8'h43;
    localparam logic [7:0] CHAR_N  = 8'h4E;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_O  = 8'h4F;
    localparam logic [7:0] CHAR_K  = 8'h4B;

    localparam logic [7:0] SEG_ZERO  = 8'b1100_0000;
    localparam logic [7:0] SEG_ONE   = 8'b1111_1001;
    localparam logic [7:0] SEG_BLANK = 8'hFF;

    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_SCAN     = 2'd1,
        OP_WATCHDOG = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_DISPLAY = 2'd1,
        KIND_RESTART = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_A     = 3'd1,
        CMD_T     = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_STORE = 3'd4,
        CMD_END   = 3'd5
    } t_cmd_state;

    typedef enum logic [1:0] {
        STORE_KEEP  = 2'd0,
        STORE_BLANK = 2'd1,
        STORE_SHIFT = 2'd2
    } t_store_op;

    localparam logic [1:0] OK_LAST_IDX = 2'd3;

    function automatic logic [7:0] seg_lookup(input logic [3:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = SEG_ZERO;
            4'd1:    seg = SEG_ONE;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] ok_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CHAR_O;
            2'd1:    ch = CHAR_K;
            2'd2:    ch = CHAR_CR;
            default: ch = CHAR_LF;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// File: rtl/scdw_if.sv
// Valid/ready channel interfaces for the input items, the result items and
// the watchdog limit register. Depends on nothing.
`default_nettype none
interface scdw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface scdw_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] tx_char;
    logic [7:0] seg_pattern;
    logic [7:0] digit_enable;
    logic       last;

    modport source (output valid, output result_kind, output tx_char, output seg_pattern,
                    output digit_enable, output last, input ready);
    modport sink   (input valid, input result_kind, input tx_char, input seg_pattern,
                    input digit_enable, input last, output ready);
endinterface

interface scdw_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/serial_command_display_watchdog.sv
// Top level: command parser, multiplexed seven-segment display and watchdog.
// Depends on scdw_pkg, the interfaces in scdw_if.sv and the assertion header.
//
//   channel   direction   transaction carries
//   i_in      in          operation, rx_byte
//   o_out     out         result_kind, tx_char, seg_pattern, digit_enable, last
//   i_cfg     in          16-bit watchdog limit
//
// An item is taken into an input register, then processed into the result
// register, so one item per cycle is sustained while o_out.ready is high.
// A closing LF gives four results, O K CR LF, one per cycle from the result
// register, holding the next item until LF; results stall only on o_out.ready.
// Synchronous reset clears all control state; the limit register goes to 32768.
`default_nettype none
`include "serial_command_display_watchdog_assert.svh"
module serial_command_display_watchdog (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    scdw_in_if.sink      i_in,
    scdw_out_if.source   o_out,
    scdw_cfg_if.sink     i_cfg
);

    logic                          r_in_valid;
    logic [1:0]                    r_in_op;
    logic [7:0]                    r_in_byte;

    logic [15:0]                   r_limit;
    scdw_pkg::t_cmd_state          r_cmd,   n_cmd;
    logic [3:0]                    r_store [scdw_pkg::DIGIT_COUNT];
    logic [3:0]                    n_store [scdw_pkg::DIGIT_COUNT];
    logic [scdw_pkg::POS_W-1:0]    r_pos,   n_pos;
    logic [7:0]                    r_ring,  n_ring;
    logic [15:0]                   r_count, n_count;
    logic                          r_halted, n_halted;

    logic                          r_out_valid;
    scdw_pkg::t_kind               r_out_kind, n_out_kind;
    logic [7:0]                    r_out_seg,  n_out_seg;
    logic [7:0]                    r_out_en,   n_out_en;
    logic [1:0]                    r_out_idx;

    logic                          w_out_last;
    logic                          w_fire;
    logic                          w_has_result;
    logic                          w_restart;
    logic [15:0]                   w_count_inc;
    logic                          w_byte_live;
    logic                          w_is_digit;

    scdw_pkg::t_cmd_state          w_cmd_next;
    logic                          w_bad_byte;
    logic                          w_send_ok;
    scdw_pkg::t_store_op           w_store_op;

    assign w_out_last = (r_out_kind != scdw_pkg::KIND_TX) || (r_out_idx == scdw_pkg::OK_LAST_IDX);
    assign w_fire     = r_in_valid && (!r_out_valid || (o_out.ready && w_out_last));
    assign i_in.ready = !r_in_valid || w_fire;
    assign i_cfg.ready = 1'b1;

    assign w_is_digit = (r_in_byte >= scdw_pkg::CHAR_0) && (r_in_byte <= scdw_pkg::CHAR_9);

    always_comb begin
        w_cmd_next = r_cmd;
        w_bad_byte = 1'b0;
        w_send_ok  = 1'b0;
        case (r_cmd)
            scdw_pkg::CMD_IDLE: begin
                if (r_in_byte == scdw_pkg::CHAR_A) begin
                    w_cmd_next = scdw_pkg::CMD_A;
                end else if (r_in_byte == scdw_pkg::CHAR_C) begin
                    w_cmd_next = scdw_pkg::CMD_CLEAR;
                end else if (r_in_byte == scdw_pkg::CHAR_N) begin
                    w_cmd_next = scdw_pkg::CMD_STORE;
                end else begin
                    w_bad_byte = 1'b1;
                end
            end
            scdw_pkg::CMD_A: begin
                if (r_in_byte == scdw_pkg::CHAR_T) begin
                    w_cmd_next = scdw_pkg::CMD_T;
                end else begin
                    w_bad_byte = 1'b1;
                end
            end
            scdw_pkg::CMD_T, scdw_pkg::CMD_CLEAR: begin
                if (r_in_byte == scdw_pkg::CHAR_CR) begin
                    w_cmd_next = scdw_pkg::CMD_END;
                end else begin
                    w_bad_byte = 1'b1;
                end
            end
            scdw_pkg::CMD_STORE: begin
                if (r_in_byte == scdw_pkg::CHAR_CR) begin
                    w_cmd_next = scdw_pkg::CMD_END;
                end else if (!w_is_digit) begin
                    w_bad_byte = 1'b1;
                end
            end
            scdw_pkg::CMD_END: begin
                if (r_in_byte == scdw_pkg::CHAR_LF) begin
                    w_cmd_next = scdw_pkg::CMD_IDLE;
                    w_send_ok  = 1'b1;
                end else begin
                    w_bad_byte = 1'b1;
                end
            end
            default: begin
                w_bad_byte = 1'b1;
            end
        endcase
    end

    always_comb begin
        w_store_op = scdw_pkg::STORE_KEEP;
        if (r_cmd == scdw_pkg::CMD_IDLE &&
            (r_in_byte == scdw_pkg::CHAR_C || r_in_byte == scdw_pkg::CHAR_N)) begin
            w_store_op = scdw_pkg::STORE_BLANK;
        end else if (r_cmd == scdw_pkg::CMD_STORE && w_is_digit) begin
            w_store_op = scdw_pkg::STORE_SHIFT;
        end
    end

    assign w_count_inc = r_count + 16'd1;
    assign w_byte_live = !r_halted && (r_in_op == scdw_pkg::OP_BYTE);
    assign w_restart   = (r_in_op == scdw_pkg::OP_WATCHDOG) &&
                         ((w_count_inc >= r_limit) || (w_count_inc == 16'd0));

    always_comb begin
        n_cmd        = r_cmd;
        n_store      = r_store;
        n_pos        = r_pos;
        n_ring       = r_ring;
        n_count      = r_count;
        n_halted     = r_halted;
        n_out_kind   = scdw_pkg::KIND_TX;
        n_out_seg    = 8'd0;
        n_out_en     = 8'd0;
        w_has_result = 1'b0;
        if (r_in_op == scdw_pkg::OP_WATCHDOG) begin
            n_count = w_count_inc;
            if (w_restart) begin
                n_cmd    = scdw_pkg::CMD_IDLE;
                for (int i = 0; i < scdw_pkg::DIGIT_COUNT; i++) begin
                    n_store[i] = scdw_pkg::BLANK_CODE;
                end
                n_pos        = '0;
                n_ring       = 8'd0;
                n_count      = 16'd0;
                n_halted     = 1'b0;
                n_out_kind   = scdw_pkg::KIND_RESTART;
                w_has_result = 1'b1;
            end
        end else if (w_byte_live) begin
            n_count  = 16'd0;
            n_cmd    = w_cmd_next;
            n_halted = w_bad_byte;
            w_has_result = w_send_ok;
            case (w_store_op)
                scdw_pkg::STORE_BLANK: begin
                    for (int i = 0; i < scdw_pkg::DIGIT_COUNT; i++) begin
                        n_store[i] = scdw_pkg::BLANK_CODE;
                    end
                end
                scdw_pkg::STORE_SHIFT: begin
                    for (int i = 1; i < scdw_pkg::DIGIT_COUNT; i++) begin
                        n_store[i] = r_store[i-1];
                    end
                    n_store[0] = r_in_byte[3:0];
                end
                default: begin
                    n_store = r_store;
                end
            endcase
        end else if (!r_halted && r_in_op == scdw_pkg::OP_SCAN) begin
            n_ring = {r_ring[6:0], 1'b0};
            if (n_ring == 8'd0) begin
                n_ring = 8'd1;
            end
            if (r_pos == scdw_pkg::POS_W'(scdw_pkg::DIGIT_COUNT - 1)) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
            n_out_kind   = scdw_pkg::KIND_DISPLAY;
            n_out_seg    = scdw_pkg::seg_lookup(r_store[r_pos]);
            n_out_en     = n_ring;
            w_has_result = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op   <= i_in.operation;
            r_in_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= scdw_pkg::WDOG_LIMIT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_limit <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= scdw_pkg::CMD_IDLE;
            r_pos    <= '0;
            r_ring   <= 8'd0;
            r_count  <= 16'd0;
            r_halted <= 1'b0;
            for (int i = 0; i < scdw_pkg::DIGIT_COUNT; i++) begin
                r_store[i] <= scdw_pkg::BLANK_CODE;
            end
        end else if (w_fire) begin
            r_cmd    <= n_cmd;
            r_pos    <= n_pos;
            r_ring   <= n_ring;
            r_count  <= n_count;
            r_halted <= n_halted;
            r_store  <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_idx   <= 2'd0;
        end else if (w_fire) begin
            r_out_valid <= w_has_result;
            r_out_idx   <= 2'd0;
        end else if (r_out_valid && o_out.ready) begin
            if (w_out_last) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_idx <= r_out_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_kind <= scdw_pkg::KIND_TX;
        end else if (w_fire) begin
            r_out_kind <= n_out_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_seg <= n_out_seg;
            r_out_en  <= n_out_en;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_out_kind;
    assign o_out.tx_char      = (r_out_kind == scdw_pkg::KIND_TX) ?
                                scdw_pkg::ok_char(r_out_idx) : 8'd0;
    assign o_out.seg_pattern  = r_out_seg;
    assign o_out.digit_enable = r_out_en;
    assign o_out.last         = w_out_last;

    `SCDW_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_fire, r_in_valid)
    `SCDW_ASSERT_NEXT(a_ok_order, i_clk, i_rst_n,
        r_out_valid && r_out_kind == scdw_pkg::KIND_TX && o_out.ready && !w_out_last,
        r_out_valid && r_out_idx == 2'($past(r_out_idx) + 2'd1))
    `SCDW_ASSERT_NOW(a_display_onehot, i_clk, i_rst_n,
        r_out_valid && r_out_kind == scdw_pkg::KIND_DISPLAY, $onehot(r_out_en))
    `SCDW_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, w_fire && w_restart,
        r_count == 16'd0 && !r_halted && r_cmd == scdw_pkg::CMD_IDLE && r_ring == 8'd0)
    `SCDW_ASSERT_NOW(a_halt_quiet, i_clk, i_rst_n,
        w_fire && r_halted && r_in_op != scdw_pkg::OP_WATCHDOG, !w_has_result)

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for serial_command_display_watchdog: directed and random
// transactions on the input channel, a built-in predictor and a result checker.
// Depends on scdw_pkg and the channel interfaces in scdw_if.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         SETTLE      = 8;
    localparam logic [87:0] SEGMENT_ROM = {
        8'hFF, 8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
        8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx;
        logic [7:0] seg;
        logic [7:0] en;
        logic       last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    scdw_in_if  in_ch();
    scdw_out_if out_ch();
    scdw_cfg_if cfg_ch();

    serial_command_display_watchdog dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_result                        awaited_results [$];
    scdw_pkg::t_cmd_state           cmd_state;
    logic [3:0]                     digit_store [scdw_pkg::DIGIT_COUNT];
    logic [scdw_pkg::POS_W-1:0]     scan_pos;
    logic [7:0]                     ring_value;
    logic [15:0]                    wdog_count;
    logic [15:0]                    wdog_limit;
    bit                             halted;
    bit                             quiet;
    int                             effective_items;
    int                             failures;
    int                             cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void restart_prediction();
        cmd_state = scdw_pkg::CMD_IDLE;
        for (int i = 0; i < scdw_pkg::DIGIT_COUNT; i++) begin
            digit_store[i] = scdw_pkg::BLANK_CODE;
        end
        scan_pos   = '0;
        ring_value = 8'h00;
        wdog_count = 16'd0;
        halted     = 1'b0;
    endfunction

    function automatic void blank_digits();
        for (int i = 0; i < scdw_pkg::DIGIT_COUNT; i++) begin
            digit_store[i] = scdw_pkg::BLANK_CODE;
        end
    endfunction

    function automatic void expect_result(logic [1:0] kind, logic [7:0] tx,
                                          logic [7:0] seg, logic [7:0] en, logic last);
        t_result r;
        r.kind = kind;
        r.tx   = tx;
        r.seg  = seg;
        r.en   = en;
        r.last = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [7:0] digit;
        wdog_count = 16'd0;
        case (cmd_state)
            scdw_pkg::CMD_IDLE: begin
                if (b == scdw_pkg::CHAR_A) begin
                    cmd_state = scdw_pkg::CMD_A;
                end else if (b == scdw_pkg::CHAR_C) begin
                    cmd_state = scdw_pkg::CMD_CLEAR;
                    blank_digits();
                end else if (b == scdw_pkg::CHAR_N) begin
                    cmd_state = scdw_pkg::CMD_STORE;
                    blank_digits();
                end else begin
                    halted = 1'b1;
                end
            end
            scdw_pkg::CMD_A: begin
                if (b == scdw_pkg::CHAR_T) cmd_state = scdw_pkg::CMD_T;
                else halted = 1'b1;
            end
            scdw_pkg::CMD_T, scdw_pkg::CMD_CLEAR: begin
                if (b == scdw_pkg::CHAR_CR) cmd_state = scdw_pkg::CMD_END;
                else halted = 1'b1;
            end
            scdw_pkg::CMD_STORE: begin
                if (b >= scdw_pkg::CHAR_0 && b <= scdw_pkg::CHAR_9) begin
                    for (int i = scdw_pkg::DIGIT_COUNT - 1; i > 0; i--) begin
                        digit_store[i] = digit_store[i-1];
                    end
                    digit = b - scdw_pkg::CHAR_0;
                    digit_store[0] = digit[3:0];
                end else if (b == scdw_pkg::CHAR_CR) begin
                    cmd_state = scdw_pkg::CMD_END;
                end else begin
                    halted = 1'b1;
                end
            end
            scdw_pkg::CMD_END: begin
                if (b == scdw_pkg::CHAR_LF) begin
                    cmd_state = scdw_pkg::CMD_IDLE;
                    expect_result(scdw_pkg::KIND_TX, scdw_pkg::CHAR_O, 8'h00, 8'h00, 1'b0);
                    expect_result(scdw_pkg::KIND_TX, scdw_pkg::CHAR_K, 8'h00, 8'h00, 1'b0);
                    expect_result(scdw_pkg::KIND_TX, scdw_pkg::CHAR_CR, 8'h00, 8'h00, 1'b0);
                    expect_result(scdw_pkg::KIND_TX, scdw_pkg::CHAR_LF, 8'h00, 8'h00, 1'b1);
                end else begin
                    halted = 1'b1;
                end
            end
            default: halted = 1'b1;
        endcase
    endfunction

    // Returns 1 when the transaction changes state or causes a result.
    function automatic bit predict_scdw_results(logic [1:0] op, logic [7:0] b);
        logic [3:0] code;
        logic [7:0] seg;
        if (op == scdw_pkg::OP_WATCHDOG) begin
            wdog_count = wdog_count + 16'd1;
            if (wdog_count >= wdog_limit || wdog_count == 16'd0) begin
                restart_prediction();
                expect_result(scdw_pkg::KIND_RESTART, 8'h00, 8'h00, 8'h00, 1'b1);
            end
            return 1'b1;
        end
        if (halted || op == OP_UNUSED) return 1'b0;
        if (op == scdw_pkg::OP_SCAN) begin
            code = digit_store[scan_pos];
            seg  = (code <= scdw_pkg::BLANK_CODE) ? SEGMENT_ROM[code*8 +: 8]
                                                  : scdw_pkg::SEG_BLANK;
            ring_value = {ring_value[6:0], 1'b0};
            if (ring_value == 8'h00) ring_value = 8'h01;
            scan_pos = (scan_pos == scdw_pkg::POS_W'(scdw_pkg::DIGIT_COUNT - 1)) ?
                       '0 : scan_pos + 1'b1;
            expect_result(scdw_pkg::KIND_DISPLAY, 8'h00, seg, ring_value, 1'b1);
            return 1'b1;
        end
        parse_byte(b);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind = out_ch.result_kind;
            got.tx   = out_ch.tx_char;
            got.seg  = out_ch.seg_pattern;
            got.en   = out_ch.digit_enable;
            got.last = out_ch.last;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d tx %h seg %h en %h last %b",
                         $realtime, got.kind, got.tx, got.seg, got.en, got.last);
                failures++;
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    $display("%0t: expected kind %0d tx %h seg %h en %h last %b",
                             $realtime, want.kind, want.tx, want.seg, want.en, want.last);
                    $display("%0t:   actual kind %0d tx %h seg %h en %h last %b",
                             $realtime, got.kind, got.tx, got.seg, got.en, got.last);
                    failures++;
                end
            end
        end
        out_ch.ready <= !(!quiet && $urandom_range(99) < 6);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $realtime,
                     awaited_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_byte   <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        if (predict_scdw_results(op, b)) effective_items++;
    endtask

    task automatic send_text(input logic [7:0] text [$]);
        foreach (text[i]) send_event(scdw_pkg::OP_BYTE, text[i]);
    endtask

    task automatic send_ticks(input logic [1:0] op, input int count);
        repeat (count) send_event(op, 8'($urandom_range(255)));
    endtask

    task automatic wait_until_drained();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_watchdog_limit(input logic [15:0] value);
        wait_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        wdog_limit = value;
    endtask

    task automatic test_at_command();
        send_text('{scdw_pkg::CHAR_A, scdw_pkg::CHAR_T, scdw_pkg::CHAR_CR, scdw_pkg::CHAR_LF});
    endtask

    task automatic test_number_display();
        send_text('{scdw_pkg::CHAR_N, scdw_pkg::CHAR_0, scdw_pkg::CHAR_9, scdw_pkg::CHAR_CR,
                    scdw_pkg::CHAR_LF});
        send_ticks(scdw_pkg::OP_SCAN, 9);
    endtask

    task automatic test_clear_command();
        send_text('{scdw_pkg::CHAR_C, scdw_pkg::CHAR_CR, scdw_pkg::CHAR_LF});
        send_ticks(scdw_pkg::OP_SCAN, 1);
    endtask

    task automatic test_reset_limit();
        send_ticks(scdw_pkg::OP_WATCHDOG, 24);
    endtask

    task automatic test_halt_recovery();
        write_watchdog_limit(16'd1);
        send_event(scdw_pkg::OP_BYTE, 8'hFF);
        send_ticks(scdw_pkg::OP_SCAN, 1);
        send_event(scdw_pkg::OP_BYTE, scdw_pkg::CHAR_A);
        send_event(OP_UNUSED, 8'h00);
        send_ticks(scdw_pkg::OP_WATCHDOG, 1);
        send_event(OP_UNUSED, 8'hFF);
        send_ticks(scdw_pkg::OP_SCAN, 1);
    endtask

    task automatic test_watchdog_count();
        write_watchdog_limit(16'd3);
        send_event(scdw_pkg::OP_BYTE, scdw_pkg::CHAR_A);
        send_ticks(scdw_pkg::OP_WATCHDOG, 2);
        send_event(scdw_pkg::OP_BYTE, scdw_pkg::CHAR_T);
        send_ticks(scdw_pkg::OP_WATCHDOG, 3);
        send_event(scdw_pkg::OP_BYTE, 8'h00);
    endtask

    task automatic test_max_limit();
        write_watchdog_limit(16'hFFFF);
        send_event(scdw_pkg::OP_BYTE, scdw_pkg::CHAR_N);
        send_ticks(scdw_pkg::OP_WATCHDOG, 24);
    endtask

    task automatic send_random_command();
        logic [7:0] text [$];
        int         pick;
        int         k;
        pick = $urandom_range(99);
        if (pick < 30) begin
            text = '{scdw_pkg::CHAR_A, scdw_pkg::CHAR_T, scdw_pkg::CHAR_CR, scdw_pkg::CHAR_LF};
        end else if (pick < 45) begin
            text = '{scdw_pkg::CHAR_C, scdw_pkg::CHAR_CR, scdw_pkg::CHAR_LF};
        end else begin
            text = '{scdw_pkg::CHAR_N};
            repeat ($urandom_range(10)) begin
                text.push_back(8'(scdw_pkg::CHAR_0 + $urandom_range(9)));
            end
            text.push_back(scdw_pkg::CHAR_CR);
            text.push_back(scdw_pkg::CHAR_LF);
        end
        if ($urandom_range(99) < 20) begin
            k = $urandom_range(text.size() - 1);
            if ($urandom_range(1)) text[k] = 8'($urandom_range(255));
            else while (text.size() > k) void'(text.pop_back());
        end
        foreach (text[i]) begin
            if ($urandom_range(99) < 20) begin
                pick = $urandom_range(9);
                if (pick < 6) send_ticks(scdw_pkg::OP_SCAN, 1);
                else if (pick < 9) send_ticks(scdw_pkg::OP_WATCHDOG, 1);
                else send_event(OP_UNUSED, 8'($urandom_range(255)));
            end
            send_event(scdw_pkg::OP_BYTE, text[i]);
        end
        while (halted) begin
            if ($urandom_range(9) == 0) send_ticks(scdw_pkg::OP_SCAN, 1);
            else send_ticks(scdw_pkg::OP_WATCHDOG, 1);
        end
    endtask

    task automatic test_random_traffic(input logic [15:0] limit, input int target,
                                       input bit calm);
        int start;
        write_watchdog_limit(limit);
        quiet = calm;
        start = effective_items;
        while (effective_items - start < target) send_random_command();
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.operation  = scdw_pkg::OP_BYTE;
        in_ch.rx_byte    = 8'h00;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = 16'd0;
        quiet            = 1'b0;
        effective_items  = 0;
        failures         = 0;
        cycle_count      = 0;
        wdog_limit       = scdw_pkg::WDOG_LIMIT_RST;
        restart_prediction();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_at_command();
        test_number_display();
        test_clear_command();
        test_reset_limit();
        test_halt_recovery();
        test_watchdog_count();
        test_max_limit();
        test_random_traffic(16'd2, 45, 1'b0);
        test_random_traffic(16'd9, 55, 1'b1);
        test_random_traffic(16'd60, 55, 1'b0);
        test_random_traffic(16'($urandom_range(10, 300)), 60, 1'b0);

        wait_until_drained();
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/scdw_pkg.sv
rtl/scdw_if.sv
rtl/serial_command_display_watchdog.sv
tb/sv/tb_top.sv
